// ===== rtl/chunked_frame_reassembly_checker_top_assert.svh =====
// ---------------------------------------------------------------------------
// chunked frame reassembly checker assertion macros
// shared forms for the concurrent checks of the top level
// ---------------------------------------------------------------------------
`ifndef CHUNKED_FRAME_REASSEMBLY_CHECKER_TOP_ASSERT_SVH
`define CHUNKED_FRAME_REASSEMBLY_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define CFRC_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cfrc assertion failed");

// next-cycle implication
`define CFRC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cfrc assertion failed");

`endif

// ===== rtl/cfrc_pkg.sv =====
// ---------------------------------------------------------------------------
// cfrc_pkg
// types, codes and reset values of the chunked frame reassembly checker
// ---------------------------------------------------------------------------
package cfrc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MESSAGE_ID   = 3'd0,
      CSR_MAGIC        = 3'd1,
      CSR_VERSION      = 3'd2,
      CSR_HEADER_BYTES = 3'd3,
      CSR_CHUNK_MAX    = 3'd4,
      CSR_FRAME_MAX    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_IGNORED      = 3'd0,
      VERDICT_INVALID      = 3'd1,
      VERDICT_OUT_OF_ORDER = 3'd2,
      VERDICT_ACCEPTED     = 3'd3,
      VERDICT_INCOMPLETE   = 3'd4,
      VERDICT_COMPLETE     = 3'd5
   } verdict_type;

   localparam logic [31:0] RST_MESSAGE_ID   = 32'd0;
   localparam logic [31:0] RST_MAGIC        = 32'd0;
   localparam logic [7:0]  RST_VERSION      = 8'd1;
   localparam logic [15:0] RST_HEADER_BYTES = 16'd64;
   localparam logic [15:0] RST_CHUNK_MAX    = 16'd4096;
   localparam logic [23:0] RST_FRAME_MAX    = 24'd262144;

   localparam int FLAG_FIRST = 0;
   localparam int FLAG_LAST  = 1;

   typedef struct packed {
      logic [31:0] expected_message_id;
      logic [31:0] expected_magic;
      logic [7:0]  expected_version;
      logic [15:0] header_bytes;
      logic [15:0] chunk_payload_max;
      logic [23:0] frame_bytes_max;
   } cfg_type;

   typedef struct packed {
      logic        frame_open;
      logic [31:0] open_frame_number;
      logic [23:0] open_frame_size;
      logic [23:0] bytes_received;
      logic [15:0] open_chunk_total;
      logic [15:0] next_chunk_number;
   } frame_state_type;

   localparam frame_state_type FRAME_CLEAR = '0;

   typedef struct packed {
      logic [31:0] message_id;
      logic [31:0] message_length;
      logic [31:0] magic_word;
      logic [7:0]  version_number;
      logic [15:0] declared_header_size;
      logic [1:0]  edge_flags;
      logic [31:0] frame_number;
      logic [31:0] frame_size;
      logic [15:0] chunk_total;
      logic [15:0] chunk_number;
      logic [31:0] chunk_start;
      logic [15:0] chunk_length;
   } req_payload_type;

   typedef struct packed {
      verdict_type verdict;
      logic [23:0] write_start;
      logic [15:0] write_length;
      logic [31:0] done_frame_number;
      logic [23:0] done_frame_bytes;
      logic [15:0] done_chunk_total;
   } rsp_payload_type;

endpackage

// ===== rtl/cfrc_if.sv =====
// ---------------------------------------------------------------------------
// cfrc_if
// valid/ready channels for chunk headers and verdicts
// ---------------------------------------------------------------------------
interface cfrc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_id;
   logic [31:0] message_length;
   logic [31:0] magic_word;
   logic [7:0]  version_number;
   logic [15:0] declared_header_size;
   logic [1:0]  edge_flags;
   logic [31:0] frame_number;
   logic [31:0] frame_size;
   logic [15:0] chunk_total;
   logic [15:0] chunk_number;
   logic [31:0] chunk_start;
   logic [15:0] chunk_length;

   modport source (
      output valid, message_id, message_length, magic_word, version_number,
             declared_header_size, edge_flags, frame_number, frame_size,
             chunk_total, chunk_number, chunk_start, chunk_length,
      input  ready
   );
   modport sink (
      input  valid, message_id, message_length, magic_word, version_number,
             declared_header_size, edge_flags, frame_number, frame_size,
             chunk_total, chunk_number, chunk_start, chunk_length,
      output ready
   );
endinterface

interface cfrc_rsp_if import cfrc_pkg::*; ();
   logic        valid;
   logic        ready;
   verdict_type verdict;
   logic [23:0] write_start;
   logic [15:0] write_length;
   logic [31:0] done_frame_number;
   logic [23:0] done_frame_bytes;
   logic [15:0] done_chunk_total;

   modport source (
      output valid, verdict, write_start, write_length, done_frame_number,
             done_frame_bytes, done_chunk_total,
      input  ready
   );
   modport sink (
      input  valid, verdict, write_start, write_length, done_frame_number,
             done_frame_bytes, done_chunk_total,
      output ready
   );
endinterface

// ===== rtl/chunked_frame_reassembly_checker_top.sv =====
// ---------------------------------------------------------------------------
// chunked_frame_reassembly_checker_top
// judges chunk headers against the frame being reassembled
// ---------------------------------------------------------------------------
// req_ch carries one chunk header per item, rsp_ch one verdict item per
// header, in order, with a write window and the done fields of a completed
// frame. An item is taken when valid and ready are both high.
// csr_wr_en/csr_index/csr_wr_data write the check registers; write them only
// while no item is in flight.
// Path: a taken header sits in the input register, is judged combinationally
// from it and lands in the result register that drives rsp_ch.
// Throughput: one item per cycle while rsp_ch is not stalled; the frame state
// loop closes in the judge, so back-to-back chunks see each other's updates.
// When rsp_ch stalls, the result register holds and the input register still
// takes one more item; req_ch.ready then drops until the result is taken.
// Reset (synchronous, active high) empties both registers, closes any open
// frame and loads the register defaults.
// ---------------------------------------------------------------------------
`include "chunked_frame_reassembly_checker_top_assert.svh"

module chunked_frame_reassembly_checker_top import cfrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   cfrc_req_if.sink               req_ch,
   cfrc_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type         cfg;
   logic            s1_valid_ff;
   req_payload_type s1_ff;
   req_payload_type s1_in;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type rsp_in;
   frame_state_type state_ff;
   frame_state_type state_in;
   logic            out_free;
   logic            s1_move;

   cfrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   cfrc_judge u_judge (
      .cfg (cfg),
      .cur (state_ff),
      .hdr (s1_ff),
      .rsp (rsp_in),
      .nxt (state_in)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      s1_move      = s1_valid_ff && out_free;
      req_ch.ready = !s1_valid_ff || out_free;

      s1_in.message_id           = req_ch.message_id;
      s1_in.message_length       = req_ch.message_length;
      s1_in.magic_word           = req_ch.magic_word;
      s1_in.version_number       = req_ch.version_number;
      s1_in.declared_header_size = req_ch.declared_header_size;
      s1_in.edge_flags           = req_ch.edge_flags;
      s1_in.frame_number         = req_ch.frame_number;
      s1_in.frame_size           = req_ch.frame_size;
      s1_in.chunk_total          = req_ch.chunk_total;
      s1_in.chunk_number         = req_ch.chunk_number;
      s1_in.chunk_start          = req_ch.chunk_start;
      s1_in.chunk_length         = req_ch.chunk_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= FRAME_CLEAR;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.verdict           = rsp_ff.verdict;
   assign rsp_ch.write_start       = rsp_ff.write_start;
   assign rsp_ch.write_length      = rsp_ff.write_length;
   assign rsp_ch.done_frame_number = rsp_ff.done_frame_number;
   assign rsp_ch.done_frame_bytes  = rsp_ff.done_frame_bytes;
   assign rsp_ch.done_chunk_total  = rsp_ff.done_chunk_total;

   // an ignored item leaves the frame state alone
   `CFRC_ASSERT_NEXT(a_ignored_keeps_state, clock, reset,
      s1_move && (rsp_in.verdict == VERDICT_IGNORED), $stable(state_ff))

   // every verdict other than accepted or ignored closes the frame
   `CFRC_ASSERT_NEXT(a_drop_closes_frame, clock, reset,
      s1_move && (rsp_in.verdict != VERDICT_IGNORED) &&
      (rsp_in.verdict != VERDICT_ACCEPTED), !state_ff.frame_open)

   // an open frame never runs past its size or chunk count
   `CFRC_ASSERT_SAME(a_open_frame_bounds, clock, reset,
      state_ff.frame_open, (state_ff.bytes_received <= state_ff.open_frame_size) &&
      (state_ff.next_chunk_number < state_ff.open_chunk_total))

   // a write window is only given for accepted or complete chunks
   `CFRC_ASSERT_SAME(a_window_only_on_accept, clock, reset,
      rsp_valid_ff && (rsp_ff.write_length != 16'd0),
      (rsp_ff.verdict == VERDICT_ACCEPTED) || (rsp_ff.verdict == VERDICT_COMPLETE))

endmodule

// ===== rtl/cfrc_csr.sv =====
// ---------------------------------------------------------------------------
// cfrc_csr
// configuration registers, write only
// ---------------------------------------------------------------------------
module cfrc_csr import cfrc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_MESSAGE_ID:   cfg_in.expected_message_id = csr_wr_data;
            CSR_MAGIC:        cfg_in.expected_magic      = csr_wr_data;
            CSR_VERSION:      cfg_in.expected_version    = csr_wr_data[7:0];
            CSR_HEADER_BYTES: cfg_in.header_bytes        = csr_wr_data[15:0];
            CSR_CHUNK_MAX:    cfg_in.chunk_payload_max   = csr_wr_data[15:0];
            CSR_FRAME_MAX:    cfg_in.frame_bytes_max     = csr_wr_data[23:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_message_id <= RST_MESSAGE_ID;
         cfg_ff.expected_magic      <= RST_MAGIC;
         cfg_ff.expected_version    <= RST_VERSION;
         cfg_ff.header_bytes        <= RST_HEADER_BYTES;
         cfg_ff.chunk_payload_max   <= RST_CHUNK_MAX;
         cfg_ff.frame_bytes_max     <= RST_FRAME_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/cfrc_judge.sv =====
// ---------------------------------------------------------------------------
// cfrc_judge
// header checks, frame continuity and next frame state for one item
// ---------------------------------------------------------------------------
module cfrc_judge import cfrc_pkg::*; (
   input  cfg_type         cfg,
   input  frame_state_type cur,
   input  req_payload_type hdr,
   output rsp_payload_type rsp,
   output frame_state_type nxt
);

   logic            ignore;
   logic            hdr_ok;
   logic [16:0]     len_sum;
   logic [32:0]     end_sum;
   logic            first_chunk;
   logic            last_chunk;
   logic            flags_ok;
   frame_state_type base;
   logic            in_order;
   logic [23:0]     new_bytes;
   logic [15:0]     new_next;
   logic            full;

   always_comb begin
      ignore = (hdr.message_id != cfg.expected_message_id) ||
               (hdr.message_length < {16'd0, cfg.header_bytes});

      len_sum     = {1'b0, hdr.declared_header_size} + {1'b0, hdr.chunk_length};
      end_sum     = {1'b0, hdr.chunk_start} + {17'd0, hdr.chunk_length};
      first_chunk = (hdr.chunk_number == 16'd0);
      last_chunk  = (hdr.chunk_number == (hdr.chunk_total - 16'd1));
      flags_ok    = (first_chunk == hdr.edge_flags[FLAG_FIRST]) &&
                    (last_chunk == hdr.edge_flags[FLAG_LAST]);

      hdr_ok = (hdr.magic_word == cfg.expected_magic) &&
               (hdr.version_number == cfg.expected_version) &&
               (hdr.declared_header_size == cfg.header_bytes) &&
               (hdr.chunk_total != 16'd0) &&
               (hdr.chunk_number < hdr.chunk_total) &&
               (hdr.chunk_length <= cfg.chunk_payload_max) &&
               (hdr.frame_size != 32'd0) &&
               (hdr.frame_size <= {8'd0, cfg.frame_bytes_max}) &&
               (hdr.message_length == {15'd0, len_sum}) &&
               (end_sum <= {1'b0, hdr.frame_size}) &&
               flags_ok;

      // chunk zero restarts the frame
      if (first_chunk) begin
         base                   = FRAME_CLEAR;
         base.frame_open        = 1'b1;
         base.open_frame_number = hdr.frame_number;
         base.open_frame_size   = hdr.frame_size[23:0];
         base.open_chunk_total  = hdr.chunk_total;
      end else begin
         base = cur;
      end

      in_order = base.frame_open &&
                 (hdr.frame_number == base.open_frame_number) &&
                 (hdr.frame_size == {8'd0, base.open_frame_size}) &&
                 (hdr.chunk_total == base.open_chunk_total) &&
                 (hdr.chunk_number == base.next_chunk_number) &&
                 (hdr.chunk_start == {8'd0, base.bytes_received});

      new_bytes = base.bytes_received + {8'd0, hdr.chunk_length};
      new_next  = base.next_chunk_number + 16'd1;
      full      = (new_bytes == base.open_frame_size) && (new_next == base.open_chunk_total);

      rsp = '0;
      nxt = FRAME_CLEAR;
      if (ignore) begin
         rsp.verdict = VERDICT_IGNORED;
         nxt         = cur;
      end else if (!hdr_ok) begin
         rsp.verdict = VERDICT_INVALID;
      end else if (!in_order) begin
         rsp.verdict = VERDICT_OUT_OF_ORDER;
      end else if (hdr.edge_flags[FLAG_LAST]) begin
         if (full) begin
            rsp.verdict           = VERDICT_COMPLETE;
            rsp.write_start       = hdr.chunk_start[23:0];
            rsp.write_length      = hdr.chunk_length;
            rsp.done_frame_number = base.open_frame_number;
            rsp.done_frame_bytes  = base.open_frame_size;
            rsp.done_chunk_total  = base.open_chunk_total;
         end else begin
            rsp.verdict = VERDICT_INCOMPLETE;
         end
      end else begin
         rsp.verdict           = VERDICT_ACCEPTED;
         rsp.write_start       = hdr.chunk_start[23:0];
         rsp.write_length      = hdr.chunk_length;
         nxt                   = base;
         nxt.bytes_received    = new_bytes;
         nxt.next_chunk_number = new_next;
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench for chunked_frame_reassembly_checker_top
// drives chunk headers through the request channel under several register
// settings and checks each verdict item against a pinned directed value or a
// cycle-free predictor of frame reassembly; both channels idle and stall at random
// ---------------------------------------------------------------------------
module testbench;
   import cfrc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD_CYCLES = 300;

   typedef enum int unsigned {
      FLAW_DROP, FLAW_REPEAT, FLAW_OFFSET, FLAW_FRAME_NUMBER, FLAW_FLAGS,
      FLAW_MAGIC, FLAW_FOREIGN, FLAW_LENGTH, FLAW_VERSION, FLAW_TOTAL, FLAW_SIZE
   } flaw_type;

   typedef struct {
      req_payload_type item;
      bit              pinned;
      rsp_payload_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   cfrc_req_if req_ch();
   cfrc_rsp_if rsp_ch();

   chunked_frame_reassembly_checker_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   cfg_type          asm_cfg;
   frame_state_type  asm_state;
   rsp_payload_type  pending_verdicts[$];
   directed_row_type directed_table[$];

   bit          idle_enabled = 1'b1;
   bit          long_hold_req = 1'b0;
   bit          long_hold_done = 1'b0;
   int unsigned hold_off_left = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned headers_sent = 0;
   int unsigned judged_count = 0;
   int unsigned settings_count = 0;
   int unsigned verdict_seen[6];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame reassembly predictor, updates asm_state
   function automatic rsp_payload_type judge_header(input req_payload_type h);
      rsp_payload_type r;
      logic [32:0]     length_sum;
      bit              sound;
      r = '0;
      r.verdict = VERDICT_IGNORED;
      if (h.message_id != asm_cfg.expected_message_id ||
          h.message_length < asm_cfg.header_bytes)
         return r;
      length_sum = h.declared_header_size + h.chunk_length;
      sound = h.magic_word == asm_cfg.expected_magic &&
              h.version_number == asm_cfg.expected_version &&
              h.declared_header_size == asm_cfg.header_bytes &&
              h.chunk_total != 16'd0 && h.chunk_number < h.chunk_total &&
              h.chunk_length <= asm_cfg.chunk_payload_max &&
              h.frame_size != 32'd0 && h.frame_size <= asm_cfg.frame_bytes_max &&
              {1'b0, h.message_length} == length_sum &&
              h.chunk_start <= h.frame_size &&
              h.chunk_length <= h.frame_size - h.chunk_start &&
              h.edge_flags[FLAG_FIRST] == (h.chunk_number == 16'd0) &&
              h.edge_flags[FLAG_LAST] == (h.chunk_number == h.chunk_total - 16'd1);
      if (!sound) begin
         asm_state = FRAME_CLEAR;
         r.verdict = VERDICT_INVALID;
         return r;
      end
      if (h.chunk_number == 16'd0) begin
         asm_state = FRAME_CLEAR;
         asm_state.frame_open = 1'b1;
         asm_state.open_frame_number = h.frame_number;
         asm_state.open_frame_size = h.frame_size[23:0];
         asm_state.open_chunk_total = h.chunk_total;
      end
      if (!asm_state.frame_open || h.frame_number != asm_state.open_frame_number ||
          h.frame_size != {8'd0, asm_state.open_frame_size} ||
          h.chunk_total != asm_state.open_chunk_total ||
          h.chunk_number != asm_state.next_chunk_number ||
          h.chunk_start != {8'd0, asm_state.bytes_received}) begin
         asm_state = FRAME_CLEAR;
         r.verdict = VERDICT_OUT_OF_ORDER;
         return r;
      end
      asm_state.bytes_received = asm_state.bytes_received + h.chunk_length;
      asm_state.next_chunk_number = asm_state.next_chunk_number + 16'd1;
      if (h.edge_flags[FLAG_LAST]) begin
         if (asm_state.bytes_received != asm_state.open_frame_size ||
             asm_state.next_chunk_number != asm_state.open_chunk_total) begin
            asm_state = FRAME_CLEAR;
            r.verdict = VERDICT_INCOMPLETE;
            return r;
         end
         r.verdict = VERDICT_COMPLETE;
         r.write_start = h.chunk_start[23:0];
         r.write_length = h.chunk_length;
         r.done_frame_number = asm_state.open_frame_number;
         r.done_frame_bytes = asm_state.open_frame_size;
         r.done_chunk_total = asm_state.open_chunk_total;
         asm_state = FRAME_CLEAR;
         return r;
      end
      r.verdict = VERDICT_ACCEPTED;
      r.write_start = h.chunk_start[23:0];
      r.write_length = h.chunk_length;
      return r;
   endfunction

   function automatic rsp_payload_type verdict_only(input verdict_type v);
      rsp_payload_type r;
      r = '0;
      r.verdict = v;
      return r;
   endfunction

   // well-formed chunk header under the current settings
   function automatic req_payload_type chunk_header(input logic [31:0] fnum,
         input logic [31:0] fsize, input logic [15:0] total, input logic [15:0] idx,
         input logic [31:0] start, input logic [15:0] len);
      req_payload_type h;
      h.message_id = asm_cfg.expected_message_id;
      h.message_length = asm_cfg.header_bytes + len;
      h.magic_word = asm_cfg.expected_magic;
      h.version_number = asm_cfg.expected_version;
      h.declared_header_size = asm_cfg.header_bytes;
      h.edge_flags[FLAG_FIRST] = (idx == 16'd0);
      h.edge_flags[FLAG_LAST] = (idx == total - 16'd1);
      h.frame_number = fnum;
      h.frame_size = fsize;
      h.chunk_total = total;
      h.chunk_number = idx;
      h.chunk_start = start;
      h.chunk_length = len;
      return h;
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.expected_message_id = $urandom;
      c.expected_magic = $urandom;
      c.expected_version = $urandom_range(255);
      c.header_bytes = $urandom_range(1) ? $urandom_range(1, 128) : $urandom_range(1, 65535);
      c.chunk_payload_max = $urandom_range(1, 65535);
      c.frame_bytes_max = $urandom_range(1, 24'hFFFFFF);
      return c;
   endfunction

   task automatic add_row(input req_payload_type h, input bit pinned,
         input rsp_payload_type want);
      directed_row_type row;
      row.item = h;
      row.pinned = pinned;
      row.want = want;
      directed_table.push_back(row);
   endtask

   task automatic send_header(input req_payload_type h, input bit pinned,
         input rsp_payload_type want);
      rsp_payload_type predicted;
      while (idle_enabled && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.message_id <= h.message_id;
      req_ch.message_length <= h.message_length;
      req_ch.magic_word <= h.magic_word;
      req_ch.version_number <= h.version_number;
      req_ch.declared_header_size <= h.declared_header_size;
      req_ch.edge_flags <= h.edge_flags;
      req_ch.frame_number <= h.frame_number;
      req_ch.frame_size <= h.frame_size;
      req_ch.chunk_total <= h.chunk_total;
      req_ch.chunk_number <= h.chunk_number;
      req_ch.chunk_start <= h.chunk_start;
      req_ch.chunk_length <= h.chunk_length;
      do @(posedge clock); while (!req_ch.ready);
      predicted = judge_header(h);
      pending_verdicts.push_back(pinned ? want : predicted);
      headers_sent++;
      if (predicted.verdict != VERDICT_IGNORED)
         judged_count++;
   endtask

   task automatic drain_verdicts();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_verdicts.size() != 0);
   endtask

   task automatic program_registers(input cfg_type c);
      csr_index_type idx;
      logic [31:0]   data;
      for (int i = 0; i < 6; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_MESSAGE_ID:   data = c.expected_message_id;
            CSR_MAGIC:        data = c.expected_magic;
            CSR_VERSION:      data = c.expected_version;
            CSR_HEADER_BYTES: data = c.header_bytes;
            CSR_CHUNK_MAX:    data = c.chunk_payload_max;
            default:          data = c.frame_bytes_max;
         endcase
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wr_data <= data;
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      asm_cfg = c;
      settings_count++;
   endtask

   // one frame in order, sometimes with a single flaw
   task automatic send_frame();
      logic [15:0]     sizes[$];
      int unsigned     n, cap, victim;
      logic [31:0]     sum, fnum, fsize, start;
      logic [1:0]      flip;
      bit              broken;
      flaw_type        flaw;
      req_payload_type h;
      n = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      cap = asm_cfg.chunk_payload_max;
      if (asm_cfg.frame_bytes_max / n < cap)
         cap = asm_cfg.frame_bytes_max / n;
      if ($urandom_range(1) && cap > 64)
         cap = 64;
      sum = 0;
      for (int i = 0; i < n; i++) begin
         sizes.push_back($urandom_range(cap));
         sum = sum + sizes[i];
      end
      if (sum == 0) begin
         sizes[0] = 16'd1;
         sum = 1;
      end
      fsize = sum;
      if ($urandom_range(9) == 0 && sum < asm_cfg.frame_bytes_max)
         fsize = sum + 1;
      fnum = $urandom;
      broken = ($urandom_range(3) == 0);
      victim = $urandom_range(n - 1);
      flaw = flaw_type'($urandom_range(FLAW_SIZE));
      flip = $urandom_range(1, 3);
      start = 0;
      for (int i = 0; i < n; i++) begin
         h = chunk_header(fnum, fsize, n, i, start, sizes[i]);
         start = start + sizes[i];
         if (broken && i == victim) begin
            case (flaw)
               FLAW_OFFSET:       h.chunk_start = h.chunk_start + 1;
               FLAW_FRAME_NUMBER: h.frame_number = ~h.frame_number;
               FLAW_FLAGS:        h.edge_flags = h.edge_flags ^ flip;
               FLAW_MAGIC:        h.magic_word = h.magic_word ^ (32'd1 << $urandom_range(31));
               FLAW_FOREIGN:      h.message_id = ~h.message_id;
               FLAW_LENGTH:       h.message_length = h.message_length + 1;
               FLAW_VERSION:      h.version_number = h.version_number + 8'd1;
               FLAW_TOTAL:        h.chunk_total = h.chunk_total + 16'd1;
               FLAW_SIZE:         h.frame_size = h.frame_size + 1;
               default: ;
            endcase
            if (flaw == FLAW_DROP)
               continue;
            if (flaw == FLAW_REPEAT)
               send_header(h, 1'b0, '0);
         end
         send_header(h, 1'b0, '0);
      end
   endtask

   task automatic send_noise();
      req_payload_type h;
      h.chunk_length = $urandom_range(1) ? $urandom_range(asm_cfg.chunk_payload_max) : $urandom;
      h.message_id = ($urandom_range(3) != 0) ? asm_cfg.expected_message_id : $urandom;
      h.declared_header_size = ($urandom_range(4) != 0) ? asm_cfg.header_bytes : $urandom;
      h.message_length = $urandom_range(1) ? h.declared_header_size + h.chunk_length : $urandom;
      h.magic_word = ($urandom_range(4) != 0) ? asm_cfg.expected_magic : $urandom;
      h.version_number = ($urandom_range(4) != 0) ? asm_cfg.expected_version : $urandom;
      h.edge_flags = $urandom;
      h.frame_number = $urandom;
      h.frame_size = $urandom_range(1) ? $urandom_range(asm_cfg.frame_bytes_max) : $urandom;
      h.chunk_total = $urandom_range(1) ? $urandom_range(1, 4) : $urandom;
      h.chunk_number = $urandom_range(1) ? $urandom_range(3) : $urandom;
      h.chunk_start = $urandom_range(1) ? $urandom_range(h.frame_size) : $urandom;
      send_header(h, 1'b0, '0);
   endtask

   task automatic run_mixture(input int unsigned target);
      int unsigned base;
      base = judged_count;
      while (judged_count - base < target) begin
         if ($urandom_range(99) < 80)
            send_frame();
         else
            send_noise();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want_v,
         input logic [31:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      end
   endtask

   task automatic check_verdict();
      rsp_payload_type got, want;
      got.verdict = rsp_ch.verdict;
      got.write_start = rsp_ch.write_start;
      got.write_length = rsp_ch.write_length;
      got.done_frame_number = rsp_ch.done_frame_number;
      got.done_frame_bytes = rsp_ch.done_frame_bytes;
      got.done_chunk_total = rsp_ch.done_chunk_total;
      if (pending_verdicts.size() == 0) begin
         error_count++;
         $display("%0t: verdict item with none expected, expected nothing actual %0h",
                  $time, got);
         return;
      end
      want = pending_verdicts.pop_front();
      verdict_seen[want.verdict]++;
      compare_field("verdict", want.verdict, got.verdict);
      compare_field("write_start", want.write_start, got.write_start);
      compare_field("write_length", want.write_length, got.write_length);
      compare_field("done_frame_number", want.done_frame_number, got.done_frame_number);
      compare_field("done_frame_bytes", want.done_frame_bytes, got.done_frame_bytes);
      compare_field("done_chunk_total", want.done_chunk_total, got.done_chunk_total);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_verdict();
         if (hold_off_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_left <= hold_off_left - 1;
         end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_off_left <= LONG_HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_enabled && $urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run timed out with %0d verdicts pending", $time,
                  pending_verdicts.size());
         $display("** chunked_frame_reassembly_checker_top: FAILED **");
         $finish;
      end
   end

   initial begin
      req_payload_type h;
      rsp_payload_type want;
      cfg_type         c;
      logic [31:0]     start, fnum;
      logic [15:0]     len;

      req_ch.valid = 1'b0;
      req_ch.message_id = '0;
      req_ch.message_length = '0;
      req_ch.magic_word = '0;
      req_ch.version_number = '0;
      req_ch.declared_header_size = '0;
      req_ch.edge_flags = '0;
      req_ch.frame_number = '0;
      req_ch.frame_size = '0;
      req_ch.chunk_total = '0;
      req_ch.chunk_number = '0;
      req_ch.chunk_start = '0;
      req_ch.chunk_length = '0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_MESSAGE_ID;
      csr_wr_data = '0;
      asm_cfg = {RST_MESSAGE_ID, RST_MAGIC, RST_VERSION, RST_HEADER_BYTES,
                 RST_CHUNK_MAX, RST_FRAME_MAX};
      asm_state = FRAME_CLEAR;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table under the reset settings
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.message_id = 32'hFFFF_FFFF;
      add_row(h, 1'b1, verdict_only(VERDICT_IGNORED));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.message_length = 32'd63;
      add_row(h, 1'b1, verdict_only(VERDICT_IGNORED));
      h.message_length = 32'd0;
      h.magic_word = 32'hFFFF_FFFF;
      add_row(h, 1'b1, verdict_only(VERDICT_IGNORED));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.magic_word = 32'hFFFF_FFFF;
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.version_number = 8'd0;
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.declared_header_size = 16'd65;
      h.message_length = 32'd165;
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd0, 16'd0, 32'd0, 16'd100);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd1, 32'd0, 16'd100);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd5000, 16'd1, 16'd0, 32'd0, 16'd4097);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd0, 16'd1, 16'd0, 32'd0, 16'd0);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd262145, 16'd1, 16'd0, 32'd0, 16'd100);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.message_length = 32'd165;
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd101, 16'd0);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd1, 16'd100);
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd1, 32'd100, 16'd1, 16'd0, 32'd0, 16'd100);
      h.edge_flags = 2'b10;
      add_row(h, 1'b1, verdict_only(VERDICT_INVALID));
      h = chunk_header(32'd7, 32'd300, 16'd3, 16'd1, 32'd100, 16'd100);
      add_row(h, 1'b1, verdict_only(VERDICT_OUT_OF_ORDER));
      h = chunk_header(32'hFFFF_FFFF, 32'd4096, 16'd1, 16'd0, 32'd0, 16'd4096);
      want = verdict_only(VERDICT_COMPLETE);
      want.write_length = 16'd4096;
      want.done_frame_number = 32'hFFFF_FFFF;
      want.done_frame_bytes = 24'd4096;
      want.done_chunk_total = 16'd1;
      add_row(h, 1'b1, want);
      add_row(chunk_header(32'd5, 32'd150, 16'd3, 16'd0, 32'd0, 16'd100), 1'b0, '0);
      add_row(chunk_header(32'd5, 32'd150, 16'd3, 16'd1, 32'd100, 16'd0), 1'b0, '0);
      add_row(chunk_header(32'd5, 32'd150, 16'd3, 16'd2, 32'd100, 16'd50), 1'b0, '0);
      add_row(chunk_header(32'd9, 32'd200, 16'd2, 16'd0, 32'd0, 16'd100), 1'b0, '0);
      add_row(chunk_header(32'd9, 32'd200, 16'd2, 16'd1, 32'd100, 16'd50), 1'b1,
              verdict_only(VERDICT_INCOMPLETE));
      add_row(chunk_header(32'd11, 32'd262144, 16'd64, 16'd0, 32'd0, 16'd4096), 1'b0, '0);
      add_row(chunk_header(32'd12, 32'd262144, 16'd64, 16'd0, 32'd0, 16'd4096), 1'b0, '0);
      add_row(chunk_header(32'd11, 32'd262144, 16'd64, 16'd1, 32'd4096, 16'd4096), 1'b1,
              verdict_only(VERDICT_OUT_OF_ORDER));
      foreach (directed_table[i])
         send_header(directed_table[i].item, directed_table[i].pinned, directed_table[i].want);

      // random settings, with one long receiver hold-off
      drain_verdicts();
      program_registers(random_settings());
      long_hold_req = 1'b1;
      run_mixture(300);

      // upper extremes and one frame that spans the whole 24-bit window
      drain_verdicts();
      c.expected_message_id = 32'hFFFF_FFFF;
      c.expected_magic = 32'hFFFF_FFFF;
      c.expected_version = 8'hFF;
      c.header_bytes = 16'hFFFF;
      c.chunk_payload_max = 16'hFFFF;
      c.frame_bytes_max = 24'hFF_FFFF;
      program_registers(c);
      fnum = $urandom;
      start = 0;
      for (int i = 0; i < 257; i++) begin
         len = (i == 256) ? 16'd255 : 16'hFFFF;
         send_header(chunk_header(fnum, 32'h00FF_FFFF, 16'd257, i, start, len), 1'b0, '0);
         start = start + len;
      end
      run_mixture(150);

      // lower extremes, no idling on either side
      drain_verdicts();
      c.expected_message_id = 32'd0;
      c.expected_magic = 32'd0;
      c.expected_version = 8'd0;
      c.header_bytes = 16'd1;
      c.chunk_payload_max = 16'd1;
      c.frame_bytes_max = 24'd1;
      program_registers(c);
      idle_enabled = 1'b0;
      run_mixture(150);
      idle_enabled = 1'b1;

      // zero frame limit makes every header that is not ignored invalid
      drain_verdicts();
      c = random_settings();
      c.frame_bytes_max = 24'd0;
      program_registers(c);
      run_mixture(40);

      drain_verdicts();
      program_registers(random_settings());
      run_mixture(275);
      drain_verdicts();
      program_registers(random_settings());
      run_mixture(275);

      drain_verdicts();
      repeat (8) @(posedge clock);
      $display("covered %0d chunk headers (%0d judged) under %0d register settings",
               headers_sent, judged_count, settings_count + 1);
      $display("verdicts: ignored %0d invalid %0d out-of-order %0d accepted %0d %s %0d %s %0d",
               verdict_seen[VERDICT_IGNORED], verdict_seen[VERDICT_INVALID],
               verdict_seen[VERDICT_OUT_OF_ORDER], verdict_seen[VERDICT_ACCEPTED],
               "incomplete", verdict_seen[VERDICT_INCOMPLETE],
               "complete", verdict_seen[VERDICT_COMPLETE]);
      if (error_count == 0)
         $display("** chunked_frame_reassembly_checker_top: PASSED **");
      else
         $display("** chunked_frame_reassembly_checker_top: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cfrc_pkg.sv
rtl/cfrc_if.sv
rtl/cfrc_csr.sv
rtl/cfrc_judge.sv
rtl/chunked_frame_reassembly_checker_top.sv
tb/sv/testbench.sv
